/* hdl/least_picked_fair_selector_defines.svh */
// ----------------------------------------------------------------------------
// Least-picked fair selector: assertion macros
// Shared property shorthands for the checker, clocked on clock, off in reset.
// ----------------------------------------------------------------------------
`ifndef LEAST_PICKED_FAIR_SELECTOR_DEFINES_SVH
`define LEAST_PICKED_FAIR_SELECTOR_DEFINES_SVH

// The consequent must hold at the edge after the antecedent.
`define LPFS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lpfs: next-cycle property failed");

// The consequent must hold at the same edge as the antecedent.
`define LPFS_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lpfs: same-cycle property failed");

`endif

/* hdl/lpfs_pkg.sv */
// ----------------------------------------------------------------------------
// Least-picked fair selector: package
// Sizes, beat types, microcode encodings and the microcode program.
// ----------------------------------------------------------------------------
package lpfs_pkg;

   localparam int MAX_ITEMS     = 64;
   localparam int COUNT_WIDTH   = 32;
   localparam int IDX_WIDTH     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int TIE_WIDTH     = IDX_WIDTH + 1;
   localparam int CFG_WIDTH     = 7;
   localparam int RND_WIDTH     = 31;
   localparam int RND_CNT_WIDTH = $clog2(RND_WIDTH);
   localparam int SEL_WIDTH     = 6;
   localparam int TOTAL_WIDTH   = 32;

   localparam logic [CFG_WIDTH-1:0] ITEM_COUNT_RESET = 7'd64;

   localparam logic CMD_PICK  = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   typedef struct packed {
      logic                 command;
      logic [RND_WIDTH-1:0] random_value;
   } req_payload_type;

   typedef struct packed {
      logic [SEL_WIDTH-1:0]   chosen_entry;
      logic [TOTAL_WIDTH-1:0] picks_so_far;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      SCAN_NONE,
      SCAN_MIN_TIE,
      SCAN_PICK
   } scan_op_type;

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_ACCEPT,
      ACT_INIT_DIV,
      ACT_DIV_STEP,
      ACT_COMMIT
   } act_type;

   typedef enum logic [2:0] {
      COND_ALWAYS,
      COND_PICK_TAKEN,
      COND_MORE_IDX,
      COND_DIV_MORE,
      COND_OUT_FREE
   } cond_type;

   typedef logic [2:0] step_type;

   localparam step_type STEP_WAIT     = 3'd0;
   localparam step_type STEP_SCAN_MT  = 3'd1;
   localparam step_type STEP_DRAIN_MT = 3'd2;
   localparam step_type STEP_DIV      = 3'd3;
   localparam step_type STEP_SCAN_PK  = 3'd4;
   localparam step_type STEP_DRAIN_PK = 3'd5;
   localparam step_type STEP_COMMIT   = 3'd6;

   typedef struct packed {
      logic        take;
      scan_op_type scan;
      act_type     act;
      cond_type    cond;
      step_type    target_t;
      step_type    target_f;
   } ctl_word_type;

   typedef struct packed {
      logic pick_taken;
      logic more_idx;
      logic div_more;
      logic out_free;
   } seq_status_type;

   // The microcode program. Each step names the step taken when its
   // condition holds and the one taken when it does not.
   function automatic ctl_word_type ucode_rom(input step_type step);
      ctl_word_type w;
      w.take     = 1'b0;
      w.scan     = SCAN_NONE;
      w.act      = ACT_NONE;
      w.cond     = COND_ALWAYS;
      w.target_t = STEP_WAIT;
      w.target_f = STEP_WAIT;
      unique case (step)
         STEP_WAIT: begin
            w.take     = 1'b1;
            w.act      = ACT_ACCEPT;
            w.cond     = COND_PICK_TAKEN;
            w.target_t = STEP_SCAN_MT;
            w.target_f = STEP_WAIT;
         end
         STEP_SCAN_MT: begin
            w.scan     = SCAN_MIN_TIE;
            w.cond     = COND_MORE_IDX;
            w.target_t = STEP_SCAN_MT;
            w.target_f = STEP_DRAIN_MT;
         end
         STEP_DRAIN_MT: begin
            w.act      = ACT_INIT_DIV;
            w.target_t = STEP_DIV;
         end
         STEP_DIV: begin
            w.act      = ACT_DIV_STEP;
            w.cond     = COND_DIV_MORE;
            w.target_t = STEP_DIV;
            w.target_f = STEP_SCAN_PK;
         end
         STEP_SCAN_PK: begin
            w.scan     = SCAN_PICK;
            w.cond     = COND_MORE_IDX;
            w.target_t = STEP_SCAN_PK;
            w.target_f = STEP_DRAIN_PK;
         end
         STEP_DRAIN_PK: begin
            w.target_t = STEP_COMMIT;
         end
         STEP_COMMIT: begin
            w.act      = ACT_COMMIT;
            w.cond     = COND_OUT_FREE;
            w.target_t = STEP_WAIT;
            w.target_f = STEP_COMMIT;
         end
         default: begin
            w.target_t = STEP_WAIT;
         end
      endcase
      return w;
   endfunction

endpackage

/* hdl/least_picked_fair_selector.sv */
// ----------------------------------------------------------------------------
// Least-picked fair selector
// Picks the least-picked active entry, breaking ties with a random value.
// ----------------------------------------------------------------------------
// A pick beat works over the active entries, of which there are up to 64:
// the pick counts sit in a single-read-port RAM that is scanned twice, once
// for the least count and its tie count and once to find the chosen entry,
// and between the scans a one-bit-per-cycle remainder unit reduces the
// random value modulo the tie count for the tie-break. A clear beat is taken
// while the sequencer stays in its wait step and yields no result.
// Per-entry valid bits make the clear instant, so there is no clearing pass
// after reset. A result waits in an output register, and the next beat is
// accepted while it does.
// ----------------------------------------------------------------------------
module least_picked_fair_selector
   import lpfs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_payload_type      req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_payload_type      rsp_payload,
   input  logic                 csr_write_enable,
   input  logic [CFG_WIDTH-1:0] csr_write_data
);

   ctl_word_type   ctl;
   seq_status_type status;

   logic [CFG_WIDTH-1:0]   item_count_ff;
   logic [IDX_WIDTH-1:0]   last_idx;

   logic [IDX_WIDTH-1:0]   idx_ff, idx_in;
   logic                   cmp_vld_ff, cmp_vld_in;
   scan_op_type            cmp_op_ff, cmp_op_in;
   logic [IDX_WIDTH-1:0]   cmp_idx_ff, cmp_idx_in;
   logic [COUNT_WIDTH-1:0] least_ff, least_in;
   logic [TIE_WIDTH-1:0]   ties_ff, ties_in;
   logic [RND_WIDTH-1:0]   rnd_ff, rnd_in;
   logic [RND_CNT_WIDTH-1:0] div_cnt_ff, div_cnt_in;
   logic [TIE_WIDTH-1:0]   rem_ff, rem_in;
   logic [TIE_WIDTH-1:0]   seen_ff, seen_in;
   logic                   found_ff, found_in;
   logic [IDX_WIDTH-1:0]   chosen_ff, chosen_in;
   logic [COUNT_WIDTH-1:0] chosen_cnt_ff, chosen_cnt_in;
   logic [MAX_ITEMS-1:0]   valid_ff, valid_in;
   logic [TOTAL_WIDTH-1:0] total_ff, total_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_payload_type        rsp_payload_ff, rsp_payload_in;

   logic                   req_accept;
   logic                   out_free;
   logic                   commit_go;
   logic [COUNT_WIDTH-1:0] rd_data;
   logic [COUNT_WIDTH-1:0] entry_cnt;
   logic [COUNT_WIDTH-1:0] cnt_inc;
   logic [TIE_WIDTH-1:0]   trial;

   lpfs_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctl    (ctl)
   );

   lpfs_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (MAX_ITEMS)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (commit_go),
      .wr_addr (chosen_ff),
      .wr_data (cnt_inc),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   // A register value of zero means one entry; anything above the store
   // size means the whole store.
   always_comb begin
      if (item_count_ff == '0) begin
         last_idx = '0;
      end else if (int'(item_count_ff) > MAX_ITEMS) begin
         last_idx = IDX_WIDTH'(MAX_ITEMS - 1);
      end else begin
         last_idx = IDX_WIDTH'(item_count_ff - 1'b1);
      end
   end

   assign req_stall  = !ctl.take;
   assign req_accept = req_valid && ctl.take;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign commit_go  = (ctl.act == ACT_COMMIT) && out_free;

   // An entry never written since the last clear reads as zero.
   assign entry_cnt = valid_ff[cmp_idx_ff] ? rd_data : '0;
   assign cnt_inc   = (&chosen_cnt_ff) ? chosen_cnt_ff : chosen_cnt_ff + 1'b1;
   assign trial     = {rem_ff[TIE_WIDTH-2:0], rnd_ff[RND_WIDTH-1]};

   always_comb begin
      status.pick_taken = req_accept && (req_payload.command == CMD_PICK);
      status.more_idx   = (idx_ff != last_idx);
      status.div_more   = (div_cnt_ff != '0);
      status.out_free   = out_free;
   end

   always_comb begin
      idx_in         = idx_ff;
      cmp_vld_in     = 1'b0;
      cmp_op_in      = cmp_op_ff;
      cmp_idx_in     = cmp_idx_ff;
      least_in       = least_ff;
      ties_in        = ties_ff;
      rnd_in         = rnd_ff;
      div_cnt_in     = div_cnt_ff;
      rem_in         = rem_ff;
      seen_in        = seen_ff;
      found_in       = found_ff;
      chosen_in      = chosen_ff;
      chosen_cnt_in  = chosen_cnt_ff;
      valid_in       = valid_ff;
      total_in       = total_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;

      // Issue side of the scan: the RAM answers in the next cycle.
      if (ctl.scan != SCAN_NONE) begin
         idx_in     = idx_ff + 1'b1;
         cmp_vld_in = 1'b1;
         cmp_op_in  = ctl.scan;
         cmp_idx_in = idx_ff;
      end

      // Compare side of the scan.
      if (cmp_vld_ff) begin
         case (cmp_op_ff)
            SCAN_MIN_TIE: begin
               if (entry_cnt < least_ff) begin
                  least_in = entry_cnt;
                  ties_in  = TIE_WIDTH'(1);
               end else if (entry_cnt == least_ff) begin
                  ties_in = ties_ff + 1'b1;
               end
            end
            SCAN_PICK: begin
               if (entry_cnt == least_ff) begin
                  if (!found_ff && (seen_ff == rem_ff)) begin
                     found_in      = 1'b1;
                     chosen_in     = cmp_idx_ff;
                     chosen_cnt_in = entry_cnt;
                  end
                  seen_in = seen_ff + 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      case (ctl.act)
         ACT_ACCEPT: begin
            if (req_accept) begin
               if (req_payload.command == CMD_CLEAR) begin
                  valid_in = '0;
                  total_in = '0;
               end else begin
                  rnd_in   = req_payload.random_value;
                  idx_in   = '0;
                  least_in = '1;
                  ties_in  = '0;
               end
            end
         end
         ACT_INIT_DIV: begin
            div_cnt_in = RND_CNT_WIDTH'(RND_WIDTH - 1);
            rem_in     = '0;
            idx_in     = '0;
            seen_in    = '0;
            found_in   = 1'b0;
         end
         ACT_DIV_STEP: begin
            // Restoring remainder, one bit of the random value per cycle.
            rem_in     = (trial >= ties_ff) ? trial - ties_ff : trial;
            rnd_in     = {rnd_ff[RND_WIDTH-2:0], 1'b0};
            div_cnt_in = div_cnt_ff - 1'b1;
         end
         ACT_COMMIT: begin
            if (out_free) begin
               valid_in[chosen_ff]         = 1'b1;
               total_in                    = total_ff + 1'b1;
               rsp_valid_in                = 1'b1;
               rsp_payload_in.chosen_entry = SEL_WIDTH'(chosen_ff);
               rsp_payload_in.picks_so_far = total_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_count_ff <= ITEM_COUNT_RESET;
         cmp_vld_ff    <= 1'b0;
         valid_ff      <= '0;
         total_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            item_count_ff <= csr_write_data;
         end
         cmp_vld_ff   <= cmp_vld_in;
         valid_ff     <= valid_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      cmp_op_ff      <= cmp_op_in;
      cmp_idx_ff     <= cmp_idx_in;
      least_ff       <= least_in;
      ties_ff        <= ties_in;
      rnd_ff         <= rnd_in;
      div_cnt_ff     <= div_cnt_in;
      rem_ff         <= rem_in;
      seen_ff        <= seen_in;
      found_ff       <= found_in;
      chosen_ff      <= chosen_in;
      chosen_cnt_ff  <= chosen_cnt_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

/* hdl/lpfs_ram.sv */
// ----------------------------------------------------------------------------
// Least-picked fair selector: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lpfs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/lpfs_seq.sv */
// ----------------------------------------------------------------------------
// Least-picked fair selector: microcode sequencer
// Step counter over the program ROM with two-way conditional jumps.
// ----------------------------------------------------------------------------
module lpfs_seq
   import lpfs_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  seq_status_type status,
   output ctl_word_type   ctl
);

   step_type step_ff;
   step_type step_in;
   logic     cond_true;

   always_comb begin
      ctl = ucode_rom(step_ff);
      unique case (ctl.cond)
         COND_ALWAYS:     cond_true = 1'b1;
         COND_PICK_TAKEN: cond_true = status.pick_taken;
         COND_MORE_IDX:   cond_true = status.more_idx;
         COND_DIV_MORE:   cond_true = status.div_more;
         COND_OUT_FREE:   cond_true = status.out_free;
         default:         cond_true = 1'b1;
      endcase
      step_in = cond_true ? ctl.target_t : ctl.target_f;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

/* hdl/lpfs_checker.sv */
// ----------------------------------------------------------------------------
// Least-picked fair selector: port checker
// Watches the top-level ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
`include "least_picked_fair_selector_defines.svh"

module lpfs_checker
   import lpfs_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_stall,
   input req_payload_type req_payload,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_payload
);

   // A taken pick makes the block go busy.
   `LPFS_ASSERT_NEXT(a_pick_goes_busy, req_valid && !req_stall && req_payload.command == CMD_PICK, req_stall)

   // A clear is finished in the cycle it is taken.
   `LPFS_ASSERT_NEXT(a_clear_stays_open, req_valid && !req_stall && req_payload.command == CMD_CLEAR, !req_stall)

   // A fresh result always coincides with the block being open for the next beat.
   `LPFS_ASSERT_SAME(a_result_frees_input, $rose(rsp_valid), !req_stall)

   // A stalled result beat holds.
   `LPFS_ASSERT_NEXT(a_result_holds, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))

endmodule

bind least_picked_fair_selector lpfs_checker u_lpfs_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
